[rtl/core/hcb_pkg.sv]
// Shared constants for the Huffman code builder.
`timescale 1ns / 1ps

package hcb_pkg;

  // Default sizing of the builder.
  localparam int DEF_MAX_LEAVES  = 16;
  localparam int DEF_WEIGHT_BITS = 16;

  // Fixed widths of the ports.
  localparam int LEAF_WEIGHT_W = 16;
  localparam int LEAF_INDEX_W  = 4;
  localparam int CODE_BITS_W   = 15;
  localparam int CODE_LENGTH_W = 4;

endpackage

[rtl/core/hcb_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/huffman_code_builder.sv]
// Huffman code builder: stores leaf weights, builds the tree in a node memory, emits codes.
`timescale 1ns / 1ps

// Leaf weights load at one beat per cycle while busy is low; leaves beyond MAX_LEAVES are
// dropped and reported through overflow_o. The beat with last_i high closes the set and
// raises busy. After a setup state the tree grows in a single node memory with one read
// and one write port: the merge that creates node k scans nodes 1..k-1 one per cycle and
// then passes a drain state and three write-backs; n leaves give n-1 merges. Codes then
// come out in leaf order, each leaf's path to the root walked one memory read per cycle.
// Each result is on the ports for one cycle with result_valid_o high and is not held, so
// the receiver must take it then; last_code_o marks the final result of a set. Busy falls
// in the cycle the last result is shown. The node memory needs no clearing after reset:
// every node a set reads has been written by that set.
module huffman_code_builder
  import hcb_pkg::*;
#(
  parameter int MAX_LEAVES  = DEF_MAX_LEAVES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [LEAF_WEIGHT_W-1:0] leaf_weight_i,
  input  logic                     last_i,
  output logic                     result_valid_o,
  output logic [LEAF_INDEX_W-1:0]  leaf_index_o,
  output logic [CODE_BITS_W-1:0]   code_bits_o,
  output logic [CODE_LENGTH_W-1:0] code_length_o,
  output logic                     overflow_o,
  output logic                     last_code_o
);

  localparam int NODES  = 2 * MAX_LEAVES;
  localparam int NW     = $clog2(NODES);
  localparam int SUM_W  = WEIGHT_BITS + $clog2(MAX_LEAVES);
  localparam int ENT_W  = SUM_W + NW + 1;
  localparam int IN_USE = (WEIGHT_BITS < LEAF_WEIGHT_W) ? WEIGHT_BITS : LEAF_WEIGHT_W;
  localparam int CNT_W  = ($clog2(MAX_LEAVES + 1) > LEAF_INDEX_W) ?
                          $clog2(MAX_LEAVES + 1) : LEAF_INDEX_W;
  localparam int LEN_W  = ($clog2(MAX_LEAVES) > CODE_LENGTH_W) ?
                          $clog2(MAX_LEAVES) : CODE_LENGTH_W;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WNEW  = 3'd4;
  localparam logic [2:0] S_WLO   = 3'd5;
  localparam logic [2:0] S_WHI   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] leaf_count_q, leaf_count_d;
  logic             dropped_q, dropped_d;
  logic [NW-1:0]    top_q, top_d;
  logic [NW-1:0]    k_q, k_d;
  logic [NW-1:0]    ptr_q, ptr_d;
  logic             rv_q, rv_d;
  logic [NW-1:0]    ri_q, ri_d;
  logic             bf_q, bf_d, sf_q, sf_d;
  logic [NW-1:0]    bi_q, bi_d, si_q, si_d;
  logic [SUM_W-1:0] bw_q, bw_d, sw_q, sw_d;
  logic [CNT_W-1:0] cur_q, cur_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [CODE_BITS_W-1:0] code_q, code_d;

  logic                     valid_q, valid_d;
  logic [LEAF_INDEX_W-1:0]  out_idx_q, out_idx_d;
  logic [CODE_BITS_W-1:0]   out_code_q, out_code_d;
  logic [CODE_LENGTH_W-1:0] out_len_q, out_len_d;
  logic                     out_ovf_q, out_ovf_d;
  logic                     out_last_q, out_last_d;

  logic             ram_we, ram_re;
  logic [NW-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic [SUM_W-1:0] rd_weight;
  logic [NW-1:0]    rd_parent;
  logic             rd_right;
  logic [NW:0]      two_n;

  // Entry layout: {weight, parent, right child flag}; parent zero means none.
  assign rd_weight = ram_rdata[ENT_W-1 -: SUM_W];
  assign rd_parent = ram_rdata[NW:1];
  assign rd_right  = ram_rdata[0];
  assign two_n     = (NW + 1)'(leaf_count_q) << 1;

  hcb_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NODES)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    leaf_count_d = leaf_count_q;
    dropped_d    = dropped_q;
    top_d        = top_q;
    k_d          = k_q;
    ptr_d        = ptr_q;
    rv_d         = 1'b0;
    ri_d         = ri_q;
    bf_d         = bf_q;
    sf_d         = sf_q;
    bi_d         = bi_q;
    si_d         = si_q;
    bw_d         = bw_q;
    sw_d         = sw_q;
    cur_d        = cur_q;
    len_d        = len_q;
    code_d       = code_q;
    valid_d      = 1'b0;
    out_idx_d    = out_idx_q;
    out_code_d   = out_code_q;
    out_len_d    = out_len_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = k_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = ptr_q;

    // Running least and second-least parentless node of the scan; ascending order and
    // strict compares give ties to the lower index.
    if (rv_q && (rd_parent == '0)) begin
      if (!bf_q || (rd_weight < bw_q)) begin
        si_d = bi_q;
        sw_d = bw_q;
        sf_d = bf_q;
        bi_d = ri_q;
        bw_d = rd_weight;
        bf_d = 1'b1;
      end else if (!sf_q || (rd_weight < sw_q)) begin
        si_d = ri_q;
        sw_d = rd_weight;
        sf_d = 1'b1;
      end
    end

    unique case (state_q)
      S_LOAD: begin
        if (start) begin
          if (leaf_count_q < CNT_W'(MAX_LEAVES)) begin
            ram_we       = 1'b1;
            ram_waddr    = NW'(leaf_count_q) + NW'(1);
            ram_wdata    = {SUM_W'(leaf_weight_i[IN_USE-1:0]), NW'(0), 1'b0};
            leaf_count_d = leaf_count_q + CNT_W'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_i) begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        top_d = NW'(two_n - (NW + 1)'(1));
        cur_d = '0;
        if (leaf_count_q == CNT_W'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = NW'(1);
          len_d     = '0;
          code_d    = '0;
          state_d   = S_EMIT;
        end else begin
          k_d     = NW'(leaf_count_q) + NW'(1);
          ptr_d   = NW'(1);
          bf_d    = 1'b0;
          sf_d    = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
        rv_d      = 1'b1;
        ri_d      = ptr_q;
        ptr_d     = ptr_q + NW'(1);
        if (ptr_q == (k_q - NW'(1))) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_WLO;
      end
      S_WLO: begin
        ram_we    = 1'b1;
        ram_waddr = bi_q;
        ram_wdata = {bw_q, k_q, 1'b0};
        state_d   = S_WHI;
      end
      S_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = si_q;
        ram_wdata = {sw_q, k_q, 1'b1};
        state_d   = S_WNEW;
      end
      S_WNEW: begin
        // The new node is written last: it is never node 1, so the read of node 1 here
        // already sees both child updates.
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = {SUM_W'(bw_q + sw_q), NW'(0), 1'b0};
        if (k_q == top_q) begin
          ram_re    = 1'b1;
          ram_raddr = NW'(1);
          len_d     = '0;
          code_d    = '0;
          state_d   = S_EMIT;
        end else begin
          k_d     = k_q + NW'(1);
          ptr_d   = NW'(1);
          bf_d    = 1'b0;
          sf_d    = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_EMIT: begin
        // The read data holds the node reached on the walk toward the root.
        if (rd_parent == '0) begin
          valid_d    = 1'b1;
          out_idx_d  = cur_q[LEAF_INDEX_W-1:0];
          out_code_d = code_q;
          out_len_d  = len_q[CODE_LENGTH_W-1:0];
          out_ovf_d  = dropped_q;
          out_last_d = ((cur_q + CNT_W'(1)) == leaf_count_q);
          if ((cur_q + CNT_W'(1)) == leaf_count_q) begin
            leaf_count_d = '0;
            dropped_d    = 1'b0;
            state_d      = S_LOAD;
          end else begin
            cur_d     = cur_q + CNT_W'(1);
            ram_re    = 1'b1;
            ram_raddr = NW'(cur_q) + NW'(2);
            len_d     = '0;
            code_d    = '0;
          end
        end else begin
          if (rd_right && (len_q < LEN_W'(CODE_BITS_W))) begin
            code_d[len_q[CODE_LENGTH_W-1:0]] = 1'b1;
          end
          len_d     = len_q + LEN_W'(1);
          ram_re    = 1'b1;
          ram_raddr = rd_parent;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      leaf_count_q <= '0;
      dropped_q    <= 1'b0;
      rv_q         <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      leaf_count_q <= leaf_count_d;
      dropped_q    <= dropped_d;
      rv_q         <= rv_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    k_q        <= k_d;
    ptr_q      <= ptr_d;
    ri_q       <= ri_d;
    bf_q       <= bf_d;
    sf_q       <= sf_d;
    bi_q       <= bi_d;
    si_q       <= si_d;
    bw_q       <= bw_d;
    sw_q       <= sw_d;
    cur_q      <= cur_d;
    len_q      <= len_d;
    code_q     <= code_d;
    out_idx_q  <= out_idx_d;
    out_code_q <= out_code_d;
    out_len_q  <= out_len_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
  end

  assign busy           = (state_q != S_LOAD);
  assign result_valid_o = valid_q;
  assign leaf_index_o   = out_idx_q;
  assign code_bits_o    = out_code_q;
  assign code_length_o  = out_len_q;
  assign overflow_o     = out_ovf_q;
  assign last_code_o    = out_last_q;

endmodule

[tb/sv/huffman_code_builder_tb.sv]
// Self-checking testbench for the Huffman code builder: leaf sets in, per-leaf codes checked.
`timescale 1ns / 1ps

module huffman_code_builder_tb
  import hcb_pkg::*;
;

  localparam int MAXL       = DEF_MAX_LEAVES;
  localparam int WBITS      = DEF_WEIGHT_BITS;
  localparam int SLOTS      = 2 * MAXL;
  localparam int RAND_ITEMS = 250;
  localparam int STALL_MAX  = 4000;
  localparam int PRINT_MAX  = 50;

  typedef struct packed {
    logic [LEAF_INDEX_W-1:0]  leaf_index;
    logic [CODE_BITS_W-1:0]   code_bits;
    logic [CODE_LENGTH_W-1:0] code_length;
    logic                     overflow;
    logic                     last_code;
  } code_beat_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [LEAF_WEIGHT_W-1:0] leaf_weight_i;
  logic                     last_i;
  logic                     result_valid_o;
  logic [LEAF_INDEX_W-1:0]  leaf_index_o;
  logic [CODE_BITS_W-1:0]   code_bits_o;
  logic [CODE_LENGTH_W-1:0] code_length_o;
  logic                     overflow_o;
  logic                     last_code_o;

  // Shadow tree used to predict the codes.
  logic [19:0] tree_weight [SLOTS];
  logic [4:0]  tree_parent [SLOTS];
  logic        tree_right  [SLOTS];
  int          leaves_held;
  logic        leaves_dropped;

  code_beat_t  pending_codes [$];
  int          error_count;
  int          items_sent;
  int          stall_cycles;
  bit          no_idle;

  huffman_code_builder #(
    .MAX_LEAVES (MAXL),
    .WEIGHT_BITS(WBITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .leaf_weight_i (leaf_weight_i),
    .last_i        (last_i),
    .result_valid_o(result_valid_o),
    .leaf_index_o  (leaf_index_o),
    .code_bits_o   (code_bits_o),
    .code_length_o (code_length_o),
    .overflow_o    (overflow_o),
    .last_code_o   (last_code_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_MAX) begin
      $display("%0t ERROR %s", $realtime, msg);
    end
  endtask

  // Lightest parentless node in 1..top other than skip; ties keep the lower index.
  function automatic int least_free(input int top, input int skip);
    int best;
    bit found;
    best = 0;
    found = 1'b0;
    for (int i = 1; i <= top; i++) begin
      if (tree_parent[i] == 5'd0 && i != skip) begin
        if (!found || tree_weight[i] < tree_weight[best]) begin
          best = i;
          found = 1'b1;
        end
      end
    end
    return best;
  endfunction

  task automatic take_leaf(input logic [LEAF_WEIGHT_W-1:0] w, input logic fin);
    int n;
    int lo;
    int hi;
    int node;
    int len;
    logic [63:0] path;
    code_beat_t beat;
    if (leaves_held < MAXL) begin
      leaves_held++;
      tree_weight[leaves_held] = 20'(w & ((1 << WBITS) - 1));
      tree_parent[leaves_held] = 5'd0;
      tree_right[leaves_held]  = 1'b0;
    end else begin
      leaves_dropped = 1'b1;
    end
    if (!fin) return;

    n = leaves_held;
    for (int k = n + 1; k < 2 * n; k++) begin
      lo = least_free(k - 1, 0);
      hi = least_free(k - 1, lo);
      tree_weight[k] = tree_weight[lo] + tree_weight[hi];
      tree_parent[k] = 5'd0;
      tree_right[k]  = 1'b0;
      tree_parent[lo] = 5'(k);
      tree_right[lo]  = 1'b0;
      tree_parent[hi] = 5'(k);
      tree_right[hi]  = 1'b1;
    end

    // Walking up from the leaf yields the code root bit last, so it lands on top.
    for (int i = 1; i <= n; i++) begin
      path = '0;
      len = 0;
      node = i;
      while (tree_parent[node] != 5'd0 && len < SLOTS) begin
        if (tree_right[node] && len < 63) path[len] = 1'b1;
        len++;
        node = tree_parent[node];
      end
      beat.leaf_index  = LEAF_INDEX_W'(i - 1);
      beat.code_bits   = path[CODE_BITS_W-1:0];
      beat.code_length = CODE_LENGTH_W'(len);
      beat.overflow    = leaves_dropped;
      beat.last_code   = (i == n);
      pending_codes.push_back(beat);
    end

    for (int i = 0; i < SLOTS; i++) begin
      tree_parent[i] = 5'd0;
      tree_right[i]  = 1'b0;
    end
    leaves_held = 0;
    leaves_dropped = 1'b0;
  endtask

  // Start stays high across back-to-back beats, so this task only lowers it when a gap is drawn.
  task automatic send_leaf(input logic [LEAF_WEIGHT_W-1:0] w, input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    leaf_weight_i <= w;
    last_i        <= fin;
    do @(posedge clk_i); while (busy);
    items_sent++;
    take_leaf(w, fin);
  endtask

  task automatic drain_codes();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_single_leaf();
    send_leaf(16'hFFFF, 1'b1);
    drain_codes();
  endtask

  task automatic test_extreme_pair();
    send_leaf(16'h0000, 1'b0);
    send_leaf(16'hFFFF, 1'b1);
    drain_codes();
  endtask

  task automatic test_equal_weights();
    send_leaf(16'd7, 1'b0);
    send_leaf(16'd7, 1'b0);
    send_leaf(16'd7, 1'b1);
    drain_codes();
  endtask

  // Powers of two give a chain 15 deep; the extra last leaf is dropped.
  task automatic test_overflow_chain();
    no_idle = 1'b1;
    for (int i = 0; i < MAXL; i++) begin
      send_leaf(LEAF_WEIGHT_W'(1 << i), 1'b0);
    end
    no_idle = 1'b0;
    send_leaf(16'hFFFF, 1'b1);
    drain_codes();
  endtask

  task automatic test_random_sets();
    int set_size;
    int kind;
    logic [LEAF_WEIGHT_W-1:0] w;
    while (items_sent < RAND_ITEMS) begin
      set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(MAXL + 1, MAXL + 4)
                                              : $urandom_range(1, MAXL);
      kind = $urandom_range(0, 3);
      no_idle = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < set_size; i++) begin
        case (kind)
          0: w = LEAF_WEIGHT_W'($urandom);
          1: w = LEAF_WEIGHT_W'($urandom_range(0, 3));
          2: w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: w = LEAF_WEIGHT_W'(1 << $urandom_range(0, 15));
        endcase
        send_leaf(w, i == set_size - 1);
      end
      drain_codes();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    code_beat_t seen;
    code_beat_t want;
    if (rst_ni && result_valid_o) begin
      seen = '{leaf_index_o, code_bits_o, code_length_o, overflow_o, last_code_o};
      if (pending_codes.size() == 0) begin
        report_mismatch($sformatf("unexpected code beat idx=%0d code=%h len=%0d",
                                  seen.leaf_index, seen.code_bits, seen.code_length));
      end else begin
        want = pending_codes.pop_front();
        if (seen !== want) begin
          report_mismatch($sformatf(
            "idx %0d/%0d code %h/%h len %0d/%0d ovf %b/%b last %b/%b (got/exp)",
            seen.leaf_index, want.leaf_index, seen.code_bits, want.code_bits,
            seen.code_length, want.code_length, seen.overflow, want.overflow,
            seen.last_code, want.last_code));
        end
      end
    end
  end

  // During the build of a set no beat passes on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("huffman_code_builder_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    leaf_weight_i  = '0;
    last_i         = 1'b0;
    error_count    = 0;
    items_sent     = 0;
    stall_cycles   = 0;
    no_idle        = 1'b0;
    leaves_held    = 0;
    leaves_dropped = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      tree_weight[i] = '0;
      tree_parent[i] = 5'd0;
      tree_right[i]  = 1'b0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_leaf();
    test_extreme_pair();
    test_equal_weights();
    test_overflow_chain();
    test_random_sets();

    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("huffman_code_builder_tb: done, clean");
    end else begin
      $display("huffman_code_builder_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/hcb_pkg.sv
rtl/core/hcb_ram.sv
rtl/core/huffman_code_builder.sv
tb/sv/huffman_code_builder_tb.sv
